[hw/rtl/iee_pkg.sv]
// Shared constants, types and helpers for the infix expression evaluator.
// Depends on nothing; the front end, back end, top level and testbench import it.
`default_nettype none
package iee_pkg;

   // Stack geometry
   localparam int OPND_DEPTH = 64;
   localparam int OPND_AW    = $clog2(OPND_DEPTH);
   localparam int OPND_CW    = $clog2(OPND_DEPTH + 1);
   localparam int OPER_DEPTH = 64;
   localparam int OPER_AW    = $clog2(OPER_DEPTH);
   localparam int OPER_CW    = $clog2(OPER_DEPTH + 1);

   // Request queue between front and back
   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = $clog2(Q_DEPTH);
   localparam int Q_CW    = $clog2(Q_DEPTH + 1);

   // Operator codes as kept on the operator stack
   localparam logic [2:0] CODE_LPAR = 3'd0;
   localparam logic [2:0] CODE_ADD  = 3'd1;
   localparam logic [2:0] CODE_SUB  = 3'd2;
   localparam logic [2:0] CODE_MUL  = 3'd3;
   localparam logic [2:0] CODE_DIV  = 3'd4;

   // Result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_DIVZERO   = 2'd1;
   localparam logic [1:0] ST_OVERFLOW  = 2'd2;
   localparam logic [1:0] ST_MALFORMED = 2'd3;

   // Character classes
   localparam logic [2:0] CLS_DIGIT = 3'd0;
   localparam logic [2:0] CLS_LPAR  = 3'd1;
   localparam logic [2:0] CLS_RPAR  = 3'd2;
   localparam logic [2:0] CLS_OPER  = 3'd3;
   localparam logic [2:0] CLS_BAD   = 3'd4;

   // ASCII characters
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_OPEN  = 8'h28;
   localparam logic [7:0] CH_CLOSE = 8'h29;

   // Classified request as it sits in the queue
   typedef struct packed {
      logic [2:0] cls;
      logic [3:0] digit;
      logic [2:0] code;
      logic       last;
   } iee_entry_type;

   // Binding strength of an operator code
   function automatic logic [1:0] prec(input logic [2:0] code);
      logic [1:0] p;
      p = 2'd0;
      if (code == CODE_MUL || code == CODE_DIV) p = 2'd2;
      else if (code == CODE_ADD || code == CODE_SUB) p = 2'd1;
      return p;
   endfunction

endpackage
`default_nettype wire

[hw/rtl/iee_req_if.sv]
// Request channel: one expression character per item.
// Stands alone; no package needed.
`default_nettype none
interface iee_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       is_last;
   modport source (output valid, output char_in, output is_last, input ready);
   modport sink   (input valid, input char_in, input is_last, output ready);
endinterface
`default_nettype wire

[hw/rtl/iee_rsp_if.sv]
// Response channel: expression value and status.
// Stands alone; no package needed.
`default_nettype none
interface iee_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] value;
   logic [1:0]         status;
   modport source (output valid, output value, output status, input ready);
   modport sink   (input valid, input value, input status, output ready);
endinterface
`default_nettype wire

[hw/rtl/iee_front.sv]
// Front end: accepts requests, classifies each character and queues it.
// Depends on iee_pkg and iee_req_if.
`default_nettype none
module iee_front import iee_pkg::*; (
   input  wire           clock,
   input  wire           reset,
   iee_req_if.sink       req_ch,
   output logic          q_valid,
   output iee_entry_type q_entry,
   input  wire           q_pop
);

   iee_entry_type       q_mem [Q_DEPTH];
   logic [Q_AW-1:0]     wp_ff, wp_in, rp_ff, rp_in;
   logic [Q_CW-1:0]     cnt_ff, cnt_in;
   iee_entry_type       cls_entry;
   logic                push, pop;

   // Classify the incoming character
   always_comb begin
      cls_entry       = '0;
      cls_entry.last  = req_ch.is_last;
      cls_entry.digit = 4'(req_ch.char_in - CH_ZERO);
      if (req_ch.char_in inside {[CH_ZERO:CH_NINE]}) begin
         cls_entry.cls = CLS_DIGIT;
      end else begin
         case (req_ch.char_in)
            CH_OPEN:  begin cls_entry.cls = CLS_LPAR; end
            CH_CLOSE: begin cls_entry.cls = CLS_RPAR; end
            CH_PLUS:  begin cls_entry.cls = CLS_OPER; cls_entry.code = CODE_ADD; end
            CH_MINUS: begin cls_entry.cls = CLS_OPER; cls_entry.code = CODE_SUB; end
            CH_STAR:  begin cls_entry.cls = CLS_OPER; cls_entry.code = CODE_MUL; end
            CH_SLASH: begin cls_entry.cls = CLS_OPER; cls_entry.code = CODE_DIV; end
            default:  begin cls_entry.cls = CLS_BAD; end
         endcase
      end
   end

   assign req_ch.ready = (cnt_ff != Q_CW'(Q_DEPTH));
   assign push         = req_ch.valid && req_ch.ready;
   assign q_valid      = (cnt_ff != '0);
   assign pop          = q_pop && q_valid;
   assign q_entry      = q_mem[rp_ff];

   // Advance pointers and fill count
   always_comb begin
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + Q_CW'(push) - Q_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // Hold queued entries
   always_ff @(posedge clock) begin
      if (push) q_mem[wp_ff] <= cls_entry;
   end

endmodule
`default_nettype wire

[hw/rtl/iee_div.sv]
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on nothing beyond its ports.
`default_nettype none
module iee_div (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   input  wire  [31:0] dividend,
   input  wire  [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);

   logic [31:0] rem_ff, rem_in, quo_ff, quo_in, dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, neg_ff, neg_in, done_ff, done_in;
   logic [32:0] trial;
   logic        fits;

   assign trial = {rem_ff, quo_ff[31]};
   assign fits  = (trial >= {1'b0, dvs_ff});

   // Shift-subtract one bit per cycle on magnitudes
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend[31] ? 32'd0 - dividend : dividend;
         dvs_in  = divisor[31] ? 32'd0 - divisor : divisor;
         neg_in  = dividend[31] ^ divisor[31];
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? 32'(trial - {1'b0, dvs_ff}) : trial[31:0];
         quo_in = {quo_ff[30:0], fits};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? 32'd0 - quo_ff : quo_ff;

endmodule
`default_nettype wire

[hw/rtl/iee_back.sv]
// Back end: sequencer over the operand and operator stacks, reduction and result.
// Depends on iee_pkg, iee_div and iee_rsp_if.
`default_nettype none
module iee_back import iee_pkg::*; (
   input  wire           clock,
   input  wire           reset,
   input  wire           q_valid,
   input  iee_entry_type q_entry,
   output logic          q_pop,
   iee_rsp_if.source     rsp_ch
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_PUSH  = 4'd1;
   localparam logic [3:0] S_DISP  = 4'd2;
   localparam logic [3:0] S_RDOP  = 4'd3;
   localparam logic [3:0] S_CHKOP = 4'd4;
   localparam logic [3:0] S_RDB   = 4'd5;
   localparam logic [3:0] S_RDA   = 4'd6;
   localparam logic [3:0] S_EXEC  = 4'd7;
   localparam logic [3:0] S_DIV   = 4'd8;
   localparam logic [3:0] S_WB    = 4'd9;
   localparam logic [3:0] S_FIN   = 4'd10;
   localparam logic [3:0] S_RES   = 4'd11;
   localparam logic [3:0] S_EMIT  = 4'd12;

   localparam logic [1:0] MODE_OP    = 2'd0;
   localparam logic [1:0] MODE_CLOSE = 2'd1;
   localparam logic [1:0] MODE_FINAL = 2'd2;

   localparam logic [OPND_CW-1:0] OPND_FULL = OPND_CW'(OPND_DEPTH);
   localparam logic [OPER_CW-1:0] OPER_FULL = OPER_CW'(OPER_DEPTH);

   logic [3:0]         state_ff, state_in;
   logic [1:0]         mode_ff, mode_in;
   logic [2:0]         cls_ff, cls_in, code_ff, code_in;
   logic               last_ff, last_in;
   logic [OPND_CW-1:0] opnd_cnt_ff, opnd_cnt_in;
   logic [OPER_CW-1:0] oper_cnt_ff, oper_cnt_in;
   logic [31:0]        acc_ff, acc_in, b_ff, b_in, res_ff, res_in;
   logic               innum_ff, innum_in;
   logic [1:0]         err_ff, err_in;
   logic               out_valid_ff, out_valid_in;
   logic [31:0]        out_value_ff, out_value_in;
   logic [1:0]         out_status_ff, out_status_in;

   // Stack memories and their ports
   logic [31:0]        opnd_mem [OPND_DEPTH];
   logic [2:0]         oper_mem [OPER_DEPTH];
   logic               opnd_we, opnd_re, oper_we, oper_re;
   logic [OPND_AW-1:0] opnd_wa, opnd_ra;
   logic [OPER_AW-1:0] oper_wa, oper_ra;
   logic [31:0]        opnd_wd, opnd_rd_ff;
   logic [2:0]         oper_wd, oper_rd_ff;

   logic [31:0]        prod;
   logic               div_start, div_done;
   logic [31:0]        div_q;
   logic [3:0]         fin_state;

   assign prod      = opnd_rd_ff * b_ff;
   assign fin_state = last_ff ? S_FIN : S_IDLE;

   iee_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (opnd_rd_ff),
      .divisor  (b_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // Sequence one request through push, reduce and emit
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      cls_in        = cls_ff;
      code_in       = code_ff;
      last_in       = last_ff;
      opnd_cnt_in   = opnd_cnt_ff;
      oper_cnt_in   = oper_cnt_ff;
      acc_in        = acc_ff;
      b_in          = b_ff;
      res_in        = res_ff;
      innum_in      = innum_ff;
      err_in        = err_ff;
      out_valid_in  = out_valid_ff && !rsp_ch.ready;
      out_value_in  = out_value_ff;
      out_status_in = out_status_ff;
      q_pop         = 1'b0;
      opnd_we       = 1'b0;
      opnd_wa       = opnd_cnt_ff[OPND_AW-1:0];
      opnd_wd       = acc_ff;
      opnd_re       = 1'b0;
      opnd_ra       = OPND_AW'(opnd_cnt_ff - OPND_CW'(1));
      oper_we       = 1'b0;
      oper_wa       = oper_cnt_ff[OPER_AW-1:0];
      oper_wd       = code_ff;
      oper_re       = 1'b0;
      oper_ra       = OPER_AW'(oper_cnt_ff - OPER_CW'(1));
      div_start     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               last_in = q_entry.last;
               if (err_ff != ST_OK) begin
                  if (q_entry.last) state_in = S_EMIT;
               end else if (q_entry.cls == CLS_DIGIT) begin
                  acc_in   = (acc_ff << 3) + (acc_ff << 1) + {28'd0, q_entry.digit};
                  innum_in = 1'b1;
                  if (q_entry.last) state_in = S_FIN;
               end else begin
                  cls_in   = q_entry.cls;
                  code_in  = q_entry.code;
                  state_in = S_PUSH;
               end
            end
         end
         S_PUSH: begin
            // Push the pending number, if any
            if (innum_ff) begin
               if (opnd_cnt_ff == OPND_FULL) begin
                  err_in = ST_OVERFLOW;
               end else begin
                  opnd_we     = 1'b1;
                  opnd_cnt_in = opnd_cnt_ff + OPND_CW'(1);
               end
            end
            acc_in   = '0;
            innum_in = 1'b0;
            state_in = S_DISP;
         end
         S_DISP: begin
            if (err_ff != ST_OK) begin
               state_in = fin_state;
            end else begin
               case (cls_ff)
                  CLS_LPAR: begin
                     if (oper_cnt_ff == OPER_FULL) begin
                        err_in = ST_OVERFLOW;
                     end else begin
                        oper_we     = 1'b1;
                        oper_wd     = CODE_LPAR;
                        oper_cnt_in = oper_cnt_ff + OPER_CW'(1);
                     end
                     state_in = fin_state;
                  end
                  CLS_RPAR: begin
                     mode_in  = MODE_CLOSE;
                     state_in = S_RDOP;
                  end
                  CLS_OPER: begin
                     mode_in  = MODE_OP;
                     state_in = S_RDOP;
                  end
                  default: begin
                     err_in   = ST_MALFORMED;
                     state_in = fin_state;
                  end
               endcase
            end
         end
         S_RDOP: begin
            if (oper_cnt_ff == '0) begin
               case (mode_ff)
                  MODE_OP: begin
                     if (oper_cnt_ff == OPER_FULL) begin
                        err_in = ST_OVERFLOW;
                     end else begin
                        oper_we     = 1'b1;
                        oper_cnt_in = oper_cnt_ff + OPER_CW'(1);
                     end
                     state_in = fin_state;
                  end
                  MODE_CLOSE: begin
                     err_in   = ST_MALFORMED;
                     state_in = fin_state;
                  end
                  default: begin
                     if (opnd_cnt_ff != OPND_CW'(1)) begin
                        err_in   = ST_MALFORMED;
                        state_in = S_EMIT;
                     end else begin
                        opnd_re  = 1'b1;
                        opnd_ra  = '0;
                        state_in = S_RES;
                     end
                  end
               endcase
            end else begin
               oper_re  = 1'b1;
               state_in = S_CHKOP;
            end
         end
         S_CHKOP: begin
            // Decide between reducing and ending this request
            if (mode_ff == MODE_OP && prec(oper_rd_ff) < prec(code_ff)) begin
               if (oper_cnt_ff == OPER_FULL) begin
                  err_in = ST_OVERFLOW;
               end else begin
                  oper_we     = 1'b1;
                  oper_cnt_in = oper_cnt_ff + OPER_CW'(1);
               end
               state_in = fin_state;
            end else if (mode_ff == MODE_CLOSE && oper_rd_ff == CODE_LPAR) begin
               oper_cnt_in = oper_cnt_ff - OPER_CW'(1);
               state_in    = fin_state;
            end else if (opnd_cnt_ff < OPND_CW'(2) || oper_rd_ff == CODE_LPAR) begin
               err_in   = ST_MALFORMED;
               state_in = fin_state;
            end else begin
               state_in = S_RDB;
            end
         end
         S_RDB: begin
            opnd_re  = 1'b1;
            state_in = S_RDA;
         end
         S_RDA: begin
            b_in     = opnd_rd_ff;
            opnd_re  = 1'b1;
            opnd_ra  = OPND_AW'(opnd_cnt_ff - OPND_CW'(2));
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_WB;
            case (oper_rd_ff)
               CODE_ADD: res_in = opnd_rd_ff + b_ff;
               CODE_SUB: res_in = opnd_rd_ff - b_ff;
               CODE_MUL: res_in = prod;
               default: begin
                  if (b_ff == '0) begin
                     err_in   = ST_DIVZERO;
                     state_in = fin_state;
                  end else begin
                     div_start = 1'b1;
                     state_in  = S_DIV;
                  end
               end
            endcase
         end
         S_DIV: begin
            if (div_done) begin
               res_in   = div_q;
               state_in = S_WB;
            end
         end
         S_WB: begin
            opnd_we     = 1'b1;
            opnd_wa     = OPND_AW'(opnd_cnt_ff - OPND_CW'(2));
            opnd_wd     = res_ff;
            opnd_cnt_in = opnd_cnt_ff - OPND_CW'(1);
            oper_cnt_in = oper_cnt_ff - OPER_CW'(1);
            state_in    = S_RDOP;
         end
         S_FIN: begin
            // Push a trailing number, then reduce everything
            if (err_ff != ST_OK) begin
               state_in = S_EMIT;
            end else if (innum_ff && opnd_cnt_ff == OPND_FULL) begin
               err_in   = ST_OVERFLOW;
               state_in = S_EMIT;
            end else begin
               if (innum_ff) begin
                  opnd_we     = 1'b1;
                  opnd_cnt_in = opnd_cnt_ff + OPND_CW'(1);
               end
               innum_in = 1'b0;
               mode_in  = MODE_FINAL;
               state_in = S_RDOP;
            end
         end
         S_RES: begin
            res_in   = opnd_rd_ff;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            // Load the response and clear for the next expression
            if (!out_valid_ff || rsp_ch.ready) begin
               out_valid_in  = 1'b1;
               out_value_in  = (err_ff == ST_OK) ? res_ff : 32'd0;
               out_status_in = err_ff;
               opnd_cnt_in   = '0;
               oper_cnt_in   = '0;
               acc_in        = '0;
               innum_in      = 1'b0;
               err_in        = ST_OK;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         opnd_cnt_ff  <= '0;
         oper_cnt_ff  <= '0;
         acc_ff       <= '0;
         innum_ff     <= 1'b0;
         err_ff       <= ST_OK;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         opnd_cnt_ff  <= opnd_cnt_in;
         oper_cnt_ff  <= oper_cnt_in;
         acc_ff       <= acc_in;
         innum_ff     <= innum_in;
         err_ff       <= err_in;
         out_valid_ff <= out_valid_in;
      end
      mode_ff       <= mode_in;
      cls_ff        <= cls_in;
      code_ff       <= code_in;
      last_ff       <= last_in;
      b_ff          <= b_in;
      res_ff        <= res_in;
      out_value_ff  <= out_value_in;
      out_status_ff <= out_status_in;
   end

   // Stack memories, registered read
   always_ff @(posedge clock) begin
      if (opnd_we) opnd_mem[opnd_wa] <= opnd_wd;
      if (opnd_re) opnd_rd_ff <= opnd_mem[opnd_ra];
   end

   always_ff @(posedge clock) begin
      if (oper_we) oper_mem[oper_wa] <= oper_wd;
      if (oper_re) oper_rd_ff <= oper_mem[oper_ra];
   end

   assign rsp_ch.valid  = out_valid_ff;
   assign rsp_ch.value  = out_value_ff;
   assign rsp_ch.status = out_status_ff;

   // Checks
   a_opnd_bound: assert property (@(posedge clock) disable iff (reset)
      opnd_cnt_ff <= OPND_FULL) else $error("operand count beyond depth");
   a_oper_bound: assert property (@(posedge clock) disable iff (reset)
      oper_cnt_ff <= OPER_FULL) else $error("operator count beyond depth");
   a_emit_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && (!out_valid_ff || rsp_ch.ready))
      |=> (opnd_cnt_ff == '0 && oper_cnt_ff == '0 && err_ff == ST_OK && out_valid_ff))
      else $error("state not cleared after response");
   a_div_only_exec: assert property (@(posedge clock) disable iff (reset)
      div_start |-> (state_ff == S_EXEC && b_ff != '0))
      else $error("divider started outside execute");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == S_IDLE && q_valid)) else $error("queue popped while busy");

endmodule
`default_nettype wire

[hw/rtl/infix_expression_evaluator.sv]
// Top level of the infix expression evaluator: front end, queue and back end.
// Depends on iee_pkg, iee_req_if, iee_rsp_if, iee_front and iee_back.
//
//   channel  | dir | payload                        | handshake
//   req_ch   | in  | char_in[7:0], is_last          | valid/ready
//   rsp_ch   | out | value[31:0] signed, status[1:0] | valid/ready
//
// A digit is folded into the accumulator in the back end; any other character
// is pushed and dispatched, plus a reduction for each operator applied, and a
// division waits on the bit-serial divider. The final character adds a full
// reduction and a read of the result. The four-entry queue lets requests arrive while
// the back end works. Reset is synchronous and clears counts and flags; the
// stacks hold no reset value. A stalled response holds the back end in emit.
`default_nettype none
module infix_expression_evaluator import iee_pkg::*; (
   input  wire       clock,
   input  wire       reset,
   iee_req_if.sink   req_ch,
   iee_rsp_if.source rsp_ch
);

   logic          q_valid, q_pop;
   iee_entry_type q_entry;

   iee_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .q_valid (q_valid),
      .q_entry (q_entry),
      .q_pop   (q_pop)
   );

   iee_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_entry (q_entry),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule
`default_nettype wire

[tb/tb_top.sv]
// Testbench for the infix expression evaluator: streams expression characters
// and checks each value and status against a behavioral evaluator.
// Depends on iee_pkg, iee_req_if, iee_rsp_if and infix_expression_evaluator.
`timescale 1ns / 1ps
module tb_top;
   import iee_pkg::*;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } char_item_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic [1:0]         status;
   } eval_result_type;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 600;

   logic clock = 1'b0;
   logic reset = 1'b1;

   iee_req_if req_ch ();
   iee_rsp_if rsp_ch ();

   infix_expression_evaluator dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   // Generate clock
   always #5 clock = ~clock;

   char_item_type   pending_chars[$];
   eval_result_type expected_results[$];
   int              mismatch_count = 0;
   int              idle_cycles = 0;
   bit              stim_done = 1'b0;
   bit              hold_sender = 1'b0;
   int              random_items = 0;
   bit              req_fire = 1'b0;
   bit              rsp_fire = 1'b0;

   // Evaluator state
   logic [31:0] opnd_stk[OPND_DEPTH];
   int          opnd_cnt;
   logic [2:0]  oper_stk[OPER_DEPTH];
   int          oper_cnt;
   logic [31:0] num_acc;
   bit          num_active;
   logic [1:0]  err_flag;

   function automatic int bind_level(logic [2:0] code);
      if (code == CODE_MUL || code == CODE_DIV) return 2;
      if (code == CODE_ADD || code == CODE_SUB) return 1;
      return 0;
   endfunction

   task automatic clear_eval();
      opnd_cnt = 0;
      oper_cnt = 0;
      num_acc = '0;
      num_active = 1'b0;
      err_flag = ST_OK;
   endtask

   task automatic flag_error(logic [1:0] code);
      if (err_flag == ST_OK) err_flag = code;
   endtask

   task automatic push_opnd(logic [31:0] v);
      if (opnd_cnt >= OPND_DEPTH) flag_error(ST_OVERFLOW);
      else begin
         opnd_stk[opnd_cnt] = v;
         opnd_cnt++;
      end
   endtask

   task automatic push_oper(logic [2:0] code);
      if (oper_cnt >= OPER_DEPTH) flag_error(ST_OVERFLOW);
      else begin
         oper_stk[oper_cnt] = code;
         oper_cnt++;
      end
   endtask

   // Apply the top operator to the top two operands
   task automatic apply_top();
      logic [2:0]  code;
      logic [31:0] a, b, r, ua, ub, q;
      if (err_flag != ST_OK) return;
      if (oper_cnt == 0 || opnd_cnt < 2) begin
         flag_error(ST_MALFORMED);
         return;
      end
      code = oper_stk[oper_cnt-1];
      if (code == CODE_LPAR) begin
         flag_error(ST_MALFORMED);
         return;
      end
      b = opnd_stk[opnd_cnt-1];
      a = opnd_stk[opnd_cnt-2];
      case (code)
         CODE_ADD: r = a + b;
         CODE_SUB: r = a - b;
         CODE_MUL: r = a * b;
         default: begin
            if (b == 0) begin
               flag_error(ST_DIVZERO);
               return;
            end
            ua = a[31] ? -a : a;
            ub = b[31] ? -b : b;
            q = ua / ub;
            r = (a[31] != b[31]) ? -q : q;
         end
      endcase
      oper_cnt--;
      opnd_cnt--;
      opnd_stk[opnd_cnt-1] = r;
   endtask

   task automatic eval_char(logic [7:0] c);
      logic [2:0] code;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         num_acc = num_acc * 10 + (c - CH_ZERO);
         num_active = 1'b1;
         return;
      end
      if (num_active) begin
         push_opnd(num_acc);
         num_acc = '0;
         num_active = 1'b0;
      end
      if (err_flag != ST_OK) return;
      if (c == CH_OPEN) push_oper(CODE_LPAR);
      else if (c == CH_CLOSE) begin
         while (err_flag == ST_OK && oper_cnt > 0 && oper_stk[oper_cnt-1] != CODE_LPAR)
            apply_top();
         if (err_flag != ST_OK) return;
         if (oper_cnt == 0) begin
            flag_error(ST_MALFORMED);
            return;
         end
         oper_cnt--;
      end else begin
         case (c)
            CH_PLUS:  code = CODE_ADD;
            CH_MINUS: code = CODE_SUB;
            CH_STAR:  code = CODE_MUL;
            CH_SLASH: code = CODE_DIV;
            default: begin
               flag_error(ST_MALFORMED);
               return;
            end
         endcase
         while (err_flag == ST_OK && oper_cnt > 0 &&
                bind_level(oper_stk[oper_cnt-1]) >= bind_level(code))
            apply_top();
         if (err_flag == ST_OK) push_oper(code);
      end
   endtask

   // Advance the evaluator by one accepted request
   task automatic predict_char(char_item_type it);
      eval_result_type res;
      if (err_flag == ST_OK) eval_char(it.ch);
      if (!it.last) return;
      if (num_active && err_flag == ST_OK) push_opnd(num_acc);
      while (err_flag == ST_OK && oper_cnt > 0) apply_top();
      if (err_flag == ST_OK && opnd_cnt != 1) flag_error(ST_MALFORMED);
      res.value = (err_flag == ST_OK) ? opnd_stk[0] : 32'sd0;
      res.status = err_flag;
      expected_results.push_back(res);
      clear_eval();
   endtask

   // Stimulus helpers
   task automatic add_char(logic [7:0] c, bit last = 0);
      char_item_type it;
      it.ch = c;
      it.last = last;
      pending_chars.push_back(it);
   endtask

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) add_char(s[i], i == s.len() - 1);
   endtask

   function automatic logic [7:0] rand_digit();
      return CH_ZERO + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] rand_oper();
      case ($urandom_range(0, 3))
         0: return CH_PLUS;
         1: return CH_MINUS;
         2: return CH_STAR;
         default: return CH_SLASH;
      endcase
   endfunction

   // Build a well-formed expression with random content
   task automatic add_number();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 3);
      for (int i = 0; i < n; i++) add_char(rand_digit());
   endtask

   task automatic add_term(int depth);
      if (depth > 0 && $urandom_range(0, 3) == 0) begin
         add_char(CH_OPEN);
         add_expr(depth - 1);
         add_char(CH_CLOSE);
      end else add_number();
   endtask

   task automatic add_expr(int depth);
      int n;
      n = $urandom_range(0, 4);
      add_term(depth);
      for (int i = 0; i < n; i++) begin
         add_char(rand_oper());
         add_term(depth);
      end
   endtask

   // Finish an expression by flagging the last queued request, or add one
   task automatic close_expr();
      if (pending_chars.size() > 0 && !pending_chars[$].last)
         pending_chars[$].last = 1'b1;
      else add_char(rand_digit(), 1);
   endtask

   task automatic wait_results_done();
      while (pending_chars.size() > 0 || expected_results.size() > 0) @(posedge clock);
   endtask

   // Driver: present requests at the falling edge with random gaps
   int send_gap = 0;
   always @(negedge clock) begin
      int gap;
      if (reset) begin
         req_ch.valid   <= 1'b0;
         req_ch.char_in <= '0;
         req_ch.is_last <= 1'b0;
         send_gap       <= 0;
      end else if (req_ch.valid && !req_fire) begin
         // hold until accepted
      end else begin
         gap = req_fire ? (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0)
                        : send_gap;
         if (gap > 0) begin
            send_gap     <= gap - 1;
            req_ch.valid <= 1'b0;
         end else if (pending_chars.size() > 0 && !hold_sender) begin
            send_gap       <= 0;
            req_ch.valid   <= 1'b1;
            req_ch.char_in <= pending_chars[0].ch;
            req_ch.is_last <= pending_chars[0].last;
         end else begin
            send_gap     <= 0;
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Accept requests at the rising edge and predict
   always @(posedge clock) begin
      req_fire = !reset && req_ch.valid && req_ch.ready;
      if (req_fire) predict_char(pending_chars.pop_front());
   end

   // Response backpressure
   int recv_gap = 0;
   always @(negedge clock) begin
      int gap;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         recv_gap     <= 0;
      end else begin
         gap = rsp_fire ? (($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0)
                        : recv_gap;
         if (gap > 0) begin
            recv_gap     <= gap - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            recv_gap     <= 0;
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Monitor: compare each response with the oldest expectation
   always @(posedge clock) begin
      eval_result_type exp_res;
      rsp_fire = !reset && rsp_ch.valid && rsp_ch.ready;
      if (rsp_fire) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected response: value %0d status %0d",
                        rsp_ch.value, rsp_ch.status);
         end else begin
            exp_res = expected_results.pop_front();
            if (rsp_ch.value !== exp_res.value || rsp_ch.status !== exp_res.status) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Mismatch: expected value %0d status %0d, got value %0d status %0d",
                           exp_res.value, exp_res.status, rsp_ch.value, rsp_ch.status);
            end
         end
      end
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else if (!stim_done || expected_results.size() > 0 || pending_chars.size() > 0) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      clear_eval();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed expressions
      add_text("1+2*3");
      add_text("(1+2)*3-4/2");
      add_text("4294967295");
      add_text("2147483648/0");
      add_text("0-2147483648/1");
      add_text("7/0");
      add_text("0-7/2");
      add_text("1)");
      add_text("(1");
      add_text("1 2");
      add_text("+");
      add_text("12");
      add_char(8'hFF, 1);
      add_char(8'h00, 1);
      // Min value divided by minus one wraps
      add_text("(0-2147483647-1)/(0-1)");
      // Deep nesting overflows the operator stack
      for (int i = 0; i < OPER_DEPTH + 2; i++) add_char(CH_OPEN);
      add_char(CH_ZERO, 1);
      // Many nested sums overflow the operator stack before the operand stack
      for (int i = 0; i < OPND_DEPTH + 1; i++) begin
         add_char(CH_OPEN);
         add_char(rand_digit());
         add_char(CH_PLUS);
      end
      add_char(CH_ZERO, 1);

      // Pause until all results have drained
      wait_results_done();
      hold_sender = 1'b1;
      repeat (5) @(posedge clock);
      hold_sender = 1'b0;

      // Random expressions, mostly well formed
      while (random_items < 1200) begin
         int before_sz;
         before_sz = pending_chars.size();
         case ($urandom_range(0, 9))
            0: begin
               int n;
               n = $urandom_range(1, 8);
               for (int i = 0; i < n; i++) add_char(8'($urandom_range(0, 255)));
               close_expr();
            end
            1: begin
               int n;
               n = $urandom_range(1, 10);
               for (int i = 0; i < n; i++) begin
                  case ($urandom_range(0, 3))
                     0: add_char(rand_digit());
                     1: add_char(rand_oper());
                     2: add_char(CH_OPEN);
                     default: add_char(CH_CLOSE);
                  endcase
               end
               close_expr();
            end
            default: begin
               add_expr(3);
               close_expr();
            end
         endcase
         random_items += pending_chars.size() - before_sz;
         if (pending_chars.size() > 40) while (pending_chars.size() > 10) @(posedge clock);
      end

      wait_results_done();
      stim_done = 1'b1;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

[infix_expression_evaluator.f]
hw/rtl/iee_pkg.sv
hw/rtl/iee_req_if.sv
hw/rtl/iee_rsp_if.sv
hw/rtl/iee_front.sv
hw/rtl/iee_div.sv
hw/rtl/iee_back.sv
hw/rtl/infix_expression_evaluator.sv
tb/tb_top.sv
